// ===== src/heat_relaxation_solver_macros.svh =====
// ----------------------------------------------------------------------------
// heat_relaxation_solver_macros
// Assertion macros shared by the heat relaxation solver.
// ----------------------------------------------------------------------------
`ifndef HEAT_RELAXATION_SOLVER_MACROS_SVH
`define HEAT_RELAXATION_SOLVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HRS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HRS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hrs_pkg
// Types, constants and helpers shared by the heat relaxation solver modules.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int unsigned HRS_CELLS  = 1024;
  localparam int unsigned HRS_SWEEPS = 3;

  // Configuration reset values.
  localparam logic [10:0] CELL_COUNT_RST    = 11'd1024;
  localparam logic [31:0] EPSILON_RST       = 32'd6554;
  localparam logic [15:0] BOUNDARY_HEAT_RST = 16'd100;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_CELL_COUNT    = 2'd0;
  localparam logic [1:0] REG_EPSILON       = 2'd1;
  localparam logic [1:0] REG_BOUNDARY_HEAT = 2'd2;

  // Request modes.
  localparam logic MODE_RUN  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;    // latch the requested cell index
    logic run_start;  // clear the sweep count and prime the buffer select
    logic init_wr;    // write the initial profile into both buffers
    logic rd_en;      // read both buffers at the controller address
    logic rd_req;     // read both buffers at the requested cell index
    logic flip;       // swap source and destination buffers
    logic cap_w0;     // capture the left neighbor of the window
    logic cap_w1;     // capture the center of the window
    logic cell_wr;    // write one relaxed cell and slide the window
    logic inc_count;  // count one finished sweep
    logic publish;    // make the run's buffer and count visible
    logic out_load;   // load the result register
  } hrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic centre_zero;  // center of the window is exactly zero
    logic over_eps;     // cell change exceeds the tolerance
    logic out_free;     // result register can take a new beat
  } hrs_sts_t;

  // Effective rod length: the configured count clamped to 3..cells.
  function automatic logic [31:0] rod_length(input logic [10:0] cnt, input logic [31:0] cells);
    logic [31:0] n;
    n = {21'b0, cnt};
    if (n < 32'd3) n = 32'd3;
    if (n > cells) n = cells;
    return n;
  endfunction

endpackage

// ===== src/hrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// hrs_ctrl
// Sequencer for initialization, relax sweeps, convergence checks and reads.
// ----------------------------------------------------------------------------
module hrs_ctrl #(
  parameter int unsigned CELLS            = hrs_pkg::HRS_CELLS,
  parameter int unsigned SWEEPS_PER_CHECK = hrs_pkg::HRS_SWEEPS,
  parameter int unsigned IDX_W            = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic              mode,
  input  logic [10:0]       cell_count,
  input  hrs_pkg::hrs_sts_t sts,
  output hrs_pkg::hrs_cmd_t cmd,
  output logic [IDX_W-1:0]  rd_addr,
  output logic [IDX_W-1:0]  wr_addr
);
  import hrs_pkg::*;

  localparam int unsigned K_W = $clog2(SWEEPS_PER_CHECK + 1);
  localparam logic [K_W-1:0] K_LAST = K_W'(SWEEPS_PER_CHECK - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_SW_R0,
    S_SW_R1,
    S_SW_PRIME,
    S_SW_CELL,
    S_CK_R0,
    S_CK_CMP,
    S_DONE,
    S_RD_ISSUE,
    S_RD_OUT
  } state_t;

  state_t         state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [K_W-1:0]   sweep_k, sweep_k_next;
  logic [31:0]      rod_n;
  logic [IDX_W-1:0] last_cell;
  logic [IDX_W-1:0] end_cell;

  assign rod_n     = rod_length(cell_count, 32'(CELLS));
  assign last_cell = IDX_W'(rod_n - 32'd1);
  assign end_cell  = IDX_W'(rod_n - 32'd2);
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    rd_addr      = '0;
    wr_addr      = idx;
    state_next   = state;
    idx_next     = idx;
    sweep_k_next = sweep_k;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_in = 1'b1;
          if (mode == MODE_RUN) begin
            cmd.run_start = 1'b1;
            idx_next      = '0;
            state_next    = S_INIT;
          end else begin
            state_next = S_RD_ISSUE;
          end
        end
      end
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (idx == last_cell) begin
          sweep_k_next = '0;
          state_next   = S_SW_R0;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      S_SW_R0: begin
        cmd.flip   = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = '0;
        state_next = S_SW_R1;
      end
      S_SW_R1: begin
        cmd.cap_w0 = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = IDX_W'(1);
        state_next = S_SW_PRIME;
      end
      S_SW_PRIME: begin
        cmd.cap_w1 = 1'b1;
        cmd.rd_en  = 1'b1;
        rd_addr    = IDX_W'(2);
        idx_next   = IDX_W'(1);
        state_next = S_SW_CELL;
      end
      S_SW_CELL: begin
        // A sweep ends after the first cell whose center was zero, or after the last interior cell.
        cmd.cell_wr = 1'b1;
        if (sts.centre_zero || idx == end_cell) begin
          cmd.inc_count = 1'b1;
          if (sweep_k == K_LAST) begin
            sweep_k_next = '0;
            state_next   = S_CK_R0;
          end else begin
            sweep_k_next = sweep_k + K_W'(1);
            state_next   = S_SW_R0;
          end
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx + IDX_W'(2);
          idx_next  = idx + IDX_W'(1);
        end
      end
      S_CK_R0: begin
        cmd.rd_en  = 1'b1;
        rd_addr    = IDX_W'(1);
        idx_next   = IDX_W'(1);
        state_next = S_CK_CMP;
      end
      S_CK_CMP: begin
        if (sts.over_eps) begin
          state_next = S_SW_R0;
        end else if (idx == end_cell) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx + IDX_W'(1);
          idx_next  = idx + IDX_W'(1);
        end
      end
      S_DONE: begin
        cmd.publish = 1'b1;
        state_next  = S_RD_ISSUE;
      end
      S_RD_ISSUE: begin
        cmd.rd_req = 1'b1;
        state_next = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      sweep_k <= '0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      sweep_k <= sweep_k_next;
    end
  end

endmodule

// ===== src/hrs_datapath.sv =====
// ----------------------------------------------------------------------------
// hrs_datapath
// Ping-pong cell buffers, relax window, convergence compare and result register.
// ----------------------------------------------------------------------------
module hrs_datapath #(
  parameter int unsigned CELLS = hrs_pkg::HRS_CELLS,
  parameter int unsigned IDX_W = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  hrs_pkg::hrs_cmd_t cmd,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  output hrs_pkg::hrs_sts_t sts,
  input  logic [9:0]        cell_index,
  input  logic [10:0]       cell_count,
  input  logic [31:0]       epsilon,
  input  logic [15:0]       boundary_heat,
  input  logic              rsp_stall,
  output logic              rsp_valid,
  output logic [31:0]       iterations,
  output logic [31:0]       cell_value
);
  import hrs_pkg::*;

  logic [31:0] buf_a [CELLS];
  logic [31:0] buf_b [CELLS];

  logic [31:0]      rd_a, rd_b;
  logic [31:0]      w0, w1;
  logic [9:0]       idx_q;
  logic             dest;
  logic             latest_select;
  logic [31:0]      run_count;
  logic [31:0]      sweep_count;
  logic [31:0]      rod_n;
  logic [IDX_W-1:0] mem_rd_addr;
  logic             mem_rd;
  logic [31:0]      src_val, dst_val;
  logic [33:0]      stencil_sum;
  logic [31:0]      relaxed;
  logic [31:0]      init_val;
  logic [31:0]      wr_data;
  logic             wr_a, wr_b;
  logic [31:0]      cell_diff;
  logic             in_rod;

  assign rod_n  = rod_length(cell_count, 32'(CELLS));
  assign in_rod = ({22'b0, idx_q} < rod_n);

  // dest set means buffer b is being written and buffer a is the source.
  assign src_val = dest ? rd_a : rd_b;
  assign dst_val = dest ? rd_b : rd_a;

  assign stencil_sum = {2'b0, w0} + {1'b0, w1, 1'b0} + {2'b0, src_val};
  assign relaxed     = stencil_sum[33:2];

  // Cell zero carries the boundary heat in Q16.16; all other cells start cold.
  assign init_val = (wr_addr == '0) ? {boundary_heat, 16'b0} : 32'b0;
  assign wr_data  = cmd.init_wr ? init_val : relaxed;
  assign wr_a     = cmd.init_wr || (cmd.cell_wr && !dest);
  assign wr_b     = cmd.init_wr || (cmd.cell_wr && dest);

  assign mem_rd      = cmd.rd_en || cmd.rd_req;
  assign mem_rd_addr = cmd.rd_req ? IDX_W'(idx_q) : rd_addr;

  assign cell_diff = (dst_val >= src_val) ? dst_val - src_val : src_val - dst_val;

  assign sts.centre_zero = (w1 == 32'b0);
  assign sts.over_eps    = (cell_diff > epsilon);
  assign sts.out_free    = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (wr_a) buf_a[wr_addr] <= wr_data;
    if (wr_b) buf_b[wr_addr] <= wr_data;
    if (mem_rd) begin
      rd_a <= buf_a[mem_rd_addr];
      rd_b <= buf_b[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) idx_q <= cell_index;
    if (cmd.cap_w0) w0 <= src_val;
    if (cmd.cap_w1) w1 <= src_val;
    if (cmd.cell_wr) begin
      w0 <= w1;
      w1 <= src_val;
    end
    if (cmd.out_load) begin
      iterations <= sweep_count;
      cell_value <= in_rod ? (latest_select ? rd_b : rd_a) : 32'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dest          <= 1'b0;
      latest_select <= 1'b0;
      run_count     <= '0;
      sweep_count   <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        dest      <= 1'b1;
        run_count <= '0;
      end
      if (cmd.flip) dest <= !dest;
      if (cmd.inc_count && run_count != 32'hFFFF_FFFF) run_count <= run_count + 32'd1;
      if (cmd.publish) begin
        latest_select <= dest;
        sweep_count   <= run_count;
      end
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/heat_relaxation_solver.sv =====
// A read request is accepted in idle, read from both buffers in the issue state and
// loaded into the result register in the output state once it is free. A run first
// writes the initial profile, then alternates relax sweeps with convergence checks and
// ends with a publish step. One request at a time: req_stall holds until its beat loads.
// Reset is synchronous: it clears control state and restores register defaults.
// Buffer contents are undefined after reset until the first run fills them.
// ----------------------------------------------------------------------------
// heat_relaxation_solver
// One-dimensional heat diffusion by ping-pong relaxation with a register port.
// ----------------------------------------------------------------------------
`include "heat_relaxation_solver_macros.svh"

module heat_relaxation_solver #(
  parameter int unsigned CELLS            = hrs_pkg::HRS_CELLS,
  parameter int unsigned SWEEPS_PER_CHECK = hrs_pkg::HRS_SWEEPS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic        mode,
  input  logic [9:0]  cell_index,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [31:0] iterations,
  output logic [31:0] cell_value
);
  import hrs_pkg::*;

  localparam int unsigned IDX_W = $clog2(CELLS);

  logic [10:0]      cell_count;
  logic [31:0]      epsilon;
  logic [15:0]      boundary_heat;
  logic             reg_wr;
  hrs_cmd_t         cmd;
  hrs_sts_t         sts;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_count    <= CELL_COUNT_RST;
      epsilon       <= EPSILON_RST;
      boundary_heat <= BOUNDARY_HEAT_RST;
    end else if (reg_wr) begin
      case (paddr[3:2])
        REG_CELL_COUNT:    cell_count    <= pwdata[10:0];
        REG_EPSILON:       epsilon       <= pwdata;
        REG_BOUNDARY_HEAT: boundary_heat <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CELL_COUNT:    prdata = {21'b0, cell_count};
      REG_EPSILON:       prdata = epsilon;
      REG_BOUNDARY_HEAT: prdata = {16'b0, boundary_heat};
      default:           prdata = 32'b0;
    endcase
  end

  hrs_ctrl #(
    .CELLS            (CELLS),
    .SWEEPS_PER_CHECK (SWEEPS_PER_CHECK),
    .IDX_W            (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .cell_count (cell_count),
    .sts        (sts),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  hrs_datapath #(
    .CELLS (CELLS),
    .IDX_W (IDX_W)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .rd_addr       (rd_addr),
    .wr_addr       (wr_addr),
    .sts           (sts),
    .cell_index    (cell_index),
    .cell_count    (cell_count),
    .epsilon       (epsilon),
    .boundary_heat (boundary_heat),
    .rsp_stall     (rsp_stall),
    .rsp_valid     (rsp_valid),
    .iterations    (iterations),
    .cell_value    (cell_value)
  );

  // An accepted request must take the controller out of idle.
  `HRS_ASSERT_NEXT(a_accept_goes_busy, req_valid && !req_stall, req_stall, "request accepted but controller stayed idle")
  // A result beat is only loaded when the result register can take it.
  `HRS_ASSERT_NOW(a_load_when_free, cmd.out_load, sts.out_free, "result loaded over a pending beat")
  // Every sweep starts by fetching cell zero of the new source buffer.
  `HRS_ASSERT_NOW(a_sweep_starts_at_zero, cmd.flip, cmd.rd_en && rd_addr == '0, "sweep did not start at cell zero")

endmodule

// ===== bench/tb_heat_relaxation_solver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_heat_relaxation_solver
// Self-checking bench for the heat relaxation solver. Register settings go in
// over the APB port while the block is idle. Run and read requests are then
// offered with random gaps while the result side stalls at random. A scoreboard
// class keeps its own copy of both rod buffers, relaxes them on every accepted
// run request and compares each result beat field by field, in order.
// ----------------------------------------------------------------------------
module tb_heat_relaxation_solver;
  import hrs_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int LONG_HOLD = 400;
  localparam longint unsigned RUN_LIMIT_NS = 64'd60_000_000;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        req_valid;
  logic        req_stall;
  logic        mode;
  logic [9:0]  cell_index;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [31:0] iterations;
  logic [31:0] cell_value;

  bit no_idle;
  bit long_hold;
  int runs;
  int reads;
  int settings;

  typedef struct {
    bit [31:0] iterations;
    bit [31:0] cell_value;
  } heat_report_t;

  class heat_scoreboard;
    bit [10:0]    cell_count_q;
    bit [31:0]    eps_q;
    bit [15:0]    heat_q;
    bit [31:0]    rod [2][HRS_CELLS];
    bit           latest;
    bit [31:0]    sweeps_done;
    heat_report_t pending [$];
    int           errors;
    int           beats;

    function new();
      cell_count_q = CELL_COUNT_RST;
      eps_q        = EPSILON_RST;
      heat_q       = BOUNDARY_HEAT_RST;
      latest       = 1'b0;
      sweeps_done  = '0;
      errors       = 0;
      beats        = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_CELL_COUNT:    cell_count_q = value[10:0];
        REG_EPSILON:       eps_q = value;
        REG_BOUNDARY_HEAT: heat_q = value[15:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_cells();
      int unsigned n;
      n = cell_count_q;
      if (n < 3) n = 3;
      if (n > HRS_CELLS) n = HRS_CELLS;
      return n;
    endfunction

    function int pending_count();
      return pending.size();
    endfunction

    function void relax_run();
      int unsigned n;
      int unsigned i;
      int unsigned k;
      bit          dst;
      bit          src;
      bit          stable;
      bit [33:0]   sum;
      bit [31:0]   diff;
      bit [31:0]   cnt;
      n = active_cells();
      for (i = 0; i < n; i++) begin
        rod[0][i] = '0;
        rod[1][i] = '0;
      end
      rod[0][0] = {heat_q, 16'h0000};
      rod[1][0] = {heat_q, 16'h0000};
      dst = 1'b1;
      cnt = '0;
      do begin
        for (k = 0; k < HRS_SWEEPS; k++) begin
          dst = ~dst;
          src = ~dst;
          for (i = 1; i + 1 < n; i++) begin
            sum = {2'b00, rod[src][i-1]} + {1'b0, rod[src][i], 1'b0} + {2'b00, rod[src][i+1]};
            rod[dst][i] = sum[33:2];
            // The heat front moves one cell per sweep; nothing past it changes.
            if (rod[src][i] == 0) break;
          end
          if (cnt != '1) cnt++;
        end
        src = ~dst;
        stable = 1'b1;
        for (i = 1; i + 1 < n; i++) begin
          diff = (rod[dst][i] >= rod[src][i]) ? rod[dst][i] - rod[src][i]
                                              : rod[src][i] - rod[dst][i];
          if (diff > eps_q) begin
            stable = 1'b0;
            break;
          end
        end
      end while (!stable);
      latest      = dst;
      sweeps_done = cnt;
    endfunction

    function void note_request(logic m, logic [9:0] idx);
      heat_report_t rep;
      if (m == MODE_RUN) relax_run();
      rep.iterations = sweeps_done;
      rep.cell_value = (idx < active_cells()) ? rod[latest][idx] : '0;
      pending.push_back(rep);
    endfunction

    function void check_beat(logic [31:0] it, logic [31:0] cv);
      heat_report_t exp_rep;
      beats++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result beat with no request outstanding, iterations %h cell_value %h",
                 $time, it, cv);
        return;
      end
      exp_rep = pending.pop_front();
      if (it !== exp_rep.iterations) begin
        errors++;
        $display("%0t: iterations mismatch, expected %h actual %h",
                 $time, exp_rep.iterations, it);
      end
      if (cv !== exp_rep.cell_value) begin
        errors++;
        $display("%0t: cell_value mismatch, expected %h actual %h",
                 $time, exp_rep.cell_value, cv);
      end
    endfunction
  endclass

  heat_scoreboard sb = new();

  heat_relaxation_solver i_dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .mode       (mode),
    .cell_index (cell_index),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .iterations (iterations),
    .cell_value (cell_value)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
  endtask

  // Back-to-back transfers keep psel high; it drops after the last one.
  task automatic apply_setting(input logic [10:0] cc, input logic [31:0] eps,
                               input logic [15:0] heat);
    write_register(REG_CELL_COUNT, {21'b0, cc});
    write_register(REG_EPSILON, eps);
    write_register(REG_BOUNDARY_HEAT, {16'b0, heat});
    psel    <= 1'b0;
    penable <= 1'b0;
    settings++;
  endtask

  task automatic offer_request(input logic m, input logic [9:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    mode       <= m;
    cell_index <= idx;
    do @(posedge clk); while (req_stall);
    sb.note_request(m, idx);
    if (m == MODE_RUN) runs++;
    else reads++;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // Result side: random stalls per beat, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    rsp_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold) begin
        gap = LONG_HOLD;
        long_hold = 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        rsp_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!rsp_valid);
      sb.check_beat(iterations, cell_value);
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[heat_relaxation_solver] ERROR");
    $finish;
  end

  initial begin
    int          ph;
    int          k;
    logic [10:0] cc;
    logic [31:0] eps;
    logic [15:0] heat;
    logic        m;
    logic [9:0]  idx;

    rst        <= 1'b1;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    req_valid  <= 1'b0;
    mode       <= MODE_RUN;
    cell_index <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Before any run, only an index past the rod may be read.
    apply_setting(11'd3, EPSILON_RST, BOUNDARY_HEAT_RST);
    offer_request(MODE_READ, 10'd1023);
    offer_request(MODE_READ, 10'd3);
    settle();

    // Counts below the minimum, zero tolerance and the hottest boundary.
    apply_setting(11'd0, 32'd0, 16'hFFFF);
    offer_request(MODE_RUN, 10'd1);
    offer_request(MODE_READ, 10'd0);
    offer_request(MODE_READ, 10'd2);
    settle();

    apply_setting(11'd2, 32'd0, 16'd0);
    offer_request(MODE_RUN, 10'd0);
    offer_request(MODE_READ, 10'd1);
    settle();

    apply_setting(11'd5, 32'd0, 16'hFFFF);
    offer_request(MODE_RUN, 10'd3);
    offer_request(MODE_READ, 10'd4);
    offer_request(MODE_READ, 10'd5);
    settle();

    // Full depth with a tolerance that passes the first check. This also
    // fills both buffers, so every later read hits written cells.
    apply_setting(11'd2047, 32'hFFFF_FFFF, 16'd100);
    offer_request(MODE_RUN, 10'd1023);
    offer_request(MODE_READ, 10'd0);
    offer_request(MODE_READ, 10'd3);
    offer_request(MODE_READ, 10'd4);
    settle();

    apply_setting(11'd1024, 32'hFFFF_FFFF, 16'hAAAA);
    offer_request(MODE_RUN, 10'd512);
    offer_request(MODE_READ, 10'd1);
    settle();

    apply_setting(11'd32, 32'h0001_0000, 16'd100);
    offer_request(MODE_RUN, 10'd16);
    offer_request(MODE_READ, 10'd31);
    settle();

    apply_setting(11'd6, EPSILON_RST, 16'd1);
    offer_request(MODE_RUN, 10'd2);
    offer_request(MODE_READ, 10'd5);
    settle();

    // Fill the block behind a long result hold-off, then drain fully.
    apply_setting(11'd4, EPSILON_RST, 16'd100);
    no_idle   = 1'b1;
    long_hold = 1'b1;
    offer_request(MODE_RUN, 10'd1);
    for (k = 0; k < 11; k++) begin
      offer_request(MODE_READ, 10'($urandom_range(0, 1023)));
    end
    settle();
    no_idle = 1'b0;

    for (ph = 0; ph < 10; ph++) begin
      no_idle = (ph % 4 == 3);
      if (ph == 5) begin
        cc   = 11'($urandom_range(1024, 2047));
        eps  = 32'hFFFF_FFFF;
        heat = 16'($urandom);
      end else begin
        // Short rods keep runs brief; zero tolerance only on the shortest.
        cc   = 11'($urandom_range(0, 8));
        heat = 16'($urandom);
        case ($urandom_range(0, 3))
          0:       eps = (cc <= 6) ? 32'd0 : 32'd1;
          1:       eps = $urandom_range(1, 65535);
          2:       eps = $urandom;
          default: eps = 32'hFFFF_FFFF;
        endcase
      end
      apply_setting(cc, eps, heat);
      for (k = 0; k < 7; k++) begin
        m   = ($urandom_range(0, 1) == 0) ? MODE_RUN : MODE_READ;
        idx = $urandom_range(0, 1) ? 10'($urandom_range(0, 1023))
                                   : 10'($urandom_range(0, sb.active_cells() - 1));
        offer_request(m, idx);
      end
      settle();
    end
    no_idle = 1'b0;

    repeat (10) @(posedge clk);
    $display("Covered %0d solver runs and %0d cell reads over %0d register settings.",
             runs, reads, settings);
    $display("Checked %0d result beats, rods from the clamped minimum to full depth.",
             sb.beats);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("[heat_relaxation_solver] OK");
    end else begin
      $display("[heat_relaxation_solver] ERROR");
    end
    $finish;
  end

endmodule

// ===== heat_relaxation_solver.f =====
+incdir+src
src/hrs_pkg.sv
src/hrs_ctrl.sv
src/hrs_datapath.sv
src/heat_relaxation_solver.sv
bench/tb_heat_relaxation_solver.sv
